/* hw/rtl/sha_pkg.sv */
// sha-256 constants, types and round functions shared by the hasher modules
`timescale 1ns / 1ps

package sha_pkg;

	localparam int BLOCK_BITS = 512;
	localparam int NUM_WORDS  = 16;
	localparam int NUM_ROUNDS = 64;
	localparam int NUM_CHAIN  = 8;

	typedef logic [31:0] word_t;
	typedef logic [7:0]  byte_t;

	typedef struct packed {
		logic       start;
		logic       clear;
		logic [2:0] sel;
	} core_ctrl_t;

	localparam word_t INIT_H [NUM_CHAIN] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam word_t ROUND_K [NUM_ROUNDS] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam byte_t PAD_BYTE  = 8'h80;
	localparam byte_t ZERO_BYTE = 8'h00;

	function automatic word_t rotr(input word_t x, input int n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

	function automatic word_t big_sigma0(input word_t x);
		big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic word_t big_sigma1(input word_t x);
		big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

	function automatic word_t small_sigma0(input word_t x);
		small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic word_t small_sigma1(input word_t x);
		small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

endpackage

/* hw/rtl/sha_stream_if.sv */
// valid/ready channel interfaces for message bytes and digest words
`timescale 1ns / 1ps

interface sha_msg_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       byte_present;
	logic       end_of_message;

	modport source (output valid, output data_byte, output byte_present,
		output end_of_message, input ready);
	modport sink (input valid, input data_byte, input byte_present,
		input end_of_message, output ready);
endinterface

interface sha_dig_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	modport source (output valid, output digest_word, output word_index,
		output last_word, input ready);
	modport sink (input valid, input digest_word, input word_index,
		input last_word, output ready);
endinterface

/* hw/rtl/sha_core.sv */
// sha-256 compression core: one round per cycle over a 16-word schedule window
`timescale 1ns / 1ps

module sha_core import sha_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  core_ctrl_t            ctrl,
	input  logic [BLOCK_BITS-1:0] block,
	output logic                  done,
	output word_t                 sel_word
);

	word_t      chain_q [NUM_CHAIN];
	word_t      v_q     [NUM_CHAIN];
	word_t      w_q     [NUM_WORDS];
	logic [5:0] rnd_q;
	logic       busy_q;
	logic       fin_q;

	word_t t1, t2, ch, mj, w_next;

	always_comb begin
		ch     = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		mj     = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
		t1     = v_q[7] + big_sigma1(v_q[4]) + ch + ROUND_K[rnd_q] + w_q[0];
		t2     = big_sigma0(v_q[0]) + mj;
		w_next = small_sigma1(w_q[14]) + w_q[9] + small_sigma0(w_q[1]) + w_q[0];
	end

	assign done     = fin_q;
	assign sel_word = chain_q[ctrl.sel];

	// control and chaining state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			fin_q   <= 1'b0;
			rnd_q   <= '0;
			chain_q <= INIT_H;
		end else begin
			fin_q <= 1'b0;
			if (ctrl.clear) begin
				chain_q <= INIT_H;
			end else if (ctrl.start) begin
				busy_q <= 1'b1;
				rnd_q  <= '0;
			end else if (busy_q) begin
				rnd_q <= rnd_q + 6'd1;
				if (rnd_q == 6'(NUM_ROUNDS - 1)) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end else if (fin_q) begin
				for (int i = 0; i < NUM_CHAIN; i++) begin
					chain_q[i] <= chain_q[i] + v_q[i];
				end
			end
		end
	end

	// working variables and schedule window
	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			for (int i = 0; i < NUM_WORDS; i++) begin
				w_q[i] <= block[BLOCK_BITS-1-32*i -: 32];
			end
			v_q <= chain_q;
		end else if (busy_q) begin
			for (int i = 0; i < NUM_WORDS - 1; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[NUM_WORDS-1] <= w_next;
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

endmodule

/* hw/rtl/sha256_stream_hasher.sv */
// top level of the sha-256 stream hasher: byte collection, padding and digest output
`timescale 1ns / 1ps

// Takes one message byte per transaction and returns the eight SHA-256 digest
// words after an end-of-message transaction. While a block fills, one byte is
// taken every cycle. The 64th byte of a block starts a compression in the
// shared round unit (load, 64 rounds, chain add), during which no byte is
// taken. At end of message the padding bytes are shifted into the block one per
// cycle (64 or 128 minus the bytes held), with one or two compressions, and the
// eight digest words then leave one per transaction, word 0 first. After the
// last word the chaining values and bit count return to their initial values.

module sha256_stream_hasher import sha_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	sha_msg_if.sink  message,
	sha_dig_if.source digest
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_PAD   = 3'd1;
	localparam logic [2:0] S_START = 3'd2;
	localparam logic [2:0] S_COMP  = 3'd3;
	localparam logic [2:0] S_OUT   = 3'd4;

	logic [2:0]            state_q;
	logic [5:0]            fill_q;
	logic [63:0]           len_q;
	logic                  pad_q;
	logic                  sent80_q;
	logic                  len_ok_q;
	logic                  final_q;
	logic [2:0]            idx_q;
	logic [BLOCK_BITS-1:0] blk_q;

	core_ctrl_t ctrl;
	logic       core_done;
	word_t      core_word;

	logic  in_take, out_take, shift_en;
	byte_t shift_byte, len_byte;

	assign message.ready = (state_q == S_IDLE);
	assign in_take       = message.valid && message.ready;
	assign digest.valid  = (state_q == S_OUT);
	assign out_take      = digest.valid && digest.ready;

	assign digest.digest_word = core_word;
	assign digest.word_index  = idx_q;
	assign digest.last_word   = (idx_q == 3'd7);

	assign ctrl.start = (state_q == S_START);
	assign ctrl.clear = out_take && (idx_q == 3'd7);
	assign ctrl.sel   = idx_q;

	// length bytes go out most significant first at block positions 56 to 63
	assign len_byte = len_q[{3'd7 - fill_q[2:0], 3'b000} +: 8];

	always_comb begin
		shift_en   = 1'b0;
		shift_byte = message.data_byte;
		if (state_q == S_IDLE) begin
			shift_en = in_take && message.byte_present;
		end else if (state_q == S_PAD) begin
			shift_en = 1'b1;
			priority if (!sent80_q) begin
				shift_byte = PAD_BYTE;
			end else if (len_ok_q && (fill_q >= 6'd56)) begin
				shift_byte = len_byte;
			end else begin
				shift_byte = ZERO_BYTE;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (shift_en) begin
			blk_q <= {blk_q[BLOCK_BITS-9:0], shift_byte};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			fill_q   <= '0;
			len_q    <= '0;
			pad_q    <= 1'b0;
			sent80_q <= 1'b0;
			len_ok_q <= 1'b0;
			final_q  <= 1'b0;
			idx_q    <= '0;
		end else begin
			if (shift_en) begin
				fill_q <= fill_q + 6'd1;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_take) begin
						sent80_q <= 1'b0;
						len_ok_q <= 1'b0;
						final_q  <= 1'b0;
						pad_q    <= message.end_of_message;
						if (message.byte_present) begin
							len_q <= len_q + 64'd8;
						end
						if (message.byte_present && (fill_q == 6'd63)) begin
							state_q <= S_START;
						end else if (message.end_of_message) begin
							state_q <= S_PAD;
						end
					end
				end
				S_PAD: begin
					if (!sent80_q) begin
						sent80_q <= 1'b1;
						if (fill_q < 6'd56) begin
							len_ok_q <= 1'b1;
						end
					end
					if (fill_q == 6'd63) begin
						state_q <= S_START;
						if (sent80_q && len_ok_q) begin
							final_q <= 1'b1;
						end
					end
				end
				S_START: begin
					state_q <= S_COMP;
				end
				S_COMP: begin
					if (core_done) begin
						// a block closed after the pad byte leaves room for the length
						if (pad_q && sent80_q) begin
							len_ok_q <= 1'b1;
						end
						priority if (final_q) begin
							state_q <= S_OUT;
							idx_q   <= '0;
						end else if (pad_q) begin
							state_q <= S_PAD;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_OUT: begin
					if (out_take) begin
						idx_q <= idx_q + 3'd1;
						if (idx_q == 3'd7) begin
							state_q <= S_IDLE;
							len_q   <= '0;
							pad_q   <= 1'b0;
							final_q <= 1'b0;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	sha_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl),
		.block    (blk_q),
		.done     (core_done),
		.sel_word (core_word)
	);

endmodule
